FILE: design/bsrf_pkg.sv
// Shared types, constants and a helper function for the bitmap store.
`timescale 1ns / 1ps

package bsrf_pkg;

    // Store geometry.
    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = 64;
    localparam int WIDX_W    = $clog2(NUM_WORDS);
    localparam int BIDX_W    = $clog2(WORD_BITS);
    localparam int HI_W      = BIDX_W + 1;

    // Field widths.
    localparam int CMD_W  = 2;
    localparam int POS_W  = 12;
    localparam int END_W  = 13;
    localparam int CAP_W  = 7;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes on the input stream.
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FILL  = 2'd3;

    // Work kinds handed from the front to the back.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_WRITE
    } bsrf_op_t;

    // One classified command.
    typedef struct packed {
        bsrf_op_t          op;
        logic [WIDX_W-1:0] first_word;
        logic [WIDX_W-1:0] last_word;
        logic [BIDX_W-1:0] lo_bit;
        logic [HI_W-1:0]   hi_bit;
        logic              value;
        logic              oor;
    } bsrf_entry_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_RESULT
    } bsrf_state_t;

    // Mask with the lowest n bits set; n of a full word or more gives all ones.
    function automatic logic [WORD_BITS-1:0] low_ones(input logic [HI_W-1:0] n);
        logic [WORD_BITS-1:0] r;
        if (n >= HI_W'(WORD_BITS)) begin
            r = '1;
        end else begin
            r = (WORD_BITS'(1) << n) - WORD_BITS'(1);
        end
        return r;
    endfunction

endpackage

FILE: design/bsrf_front.sv
// Front end: holds the capacity register and classifies each incoming command.
`timescale 1ns / 1ps

module bsrf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [bsrf_pkg::CAP_W-1:0]          cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bsrf_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                push_valid,
    input  logic                                push_ready,
    output bsrf_pkg::bsrf_entry_t               push_entry
);

    logic [bsrf_pkg::CAP_W-1:0]  cap_reg;
    logic [bsrf_pkg::CAP_W-1:0]  cap_sat;
    logic [bsrf_pkg::END_W-1:0]  cap_bits;
    logic [bsrf_pkg::CMD_W-1:0]  cmd;
    logic [bsrf_pkg::POS_W-1:0]  pos;
    logic [bsrf_pkg::END_W-1:0]  pos_x;
    logic [bsrf_pkg::END_W-1:0]  range_end;
    logic [bsrf_pkg::END_W-1:0]  end_m1;
    logic                        fill_value;
    logic [bsrf_pkg::WIDX_W-1:0] pos_word;
    logic [bsrf_pkg::BIDX_W-1:0] pos_bit;
    bsrf_pkg::bsrf_entry_t       entry;

    // Capacity register. It is to be written only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= '0;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Unpack the beat and work out the usable bit count.
    always_comb begin
        cmd        = s_tdata[bsrf_pkg::CMD_W-1:0];
        pos        = s_tdata[bsrf_pkg::CMD_W +: bsrf_pkg::POS_W];
        range_end  = s_tdata[bsrf_pkg::CMD_W + bsrf_pkg::POS_W +: bsrf_pkg::END_W];
        fill_value = s_tdata[bsrf_pkg::CMD_W + bsrf_pkg::POS_W + bsrf_pkg::END_W];
        pos_x      = bsrf_pkg::END_W'(pos);
        pos_word   = pos[bsrf_pkg::BIDX_W +: bsrf_pkg::WIDX_W];
        pos_bit    = pos[bsrf_pkg::BIDX_W-1:0];
        end_m1     = range_end - bsrf_pkg::END_W'(1);
        cap_sat    = (cap_reg > bsrf_pkg::CAP_W'(bsrf_pkg::NUM_WORDS)) ?
                     bsrf_pkg::CAP_W'(bsrf_pkg::NUM_WORDS) : cap_reg;
        cap_bits   = bsrf_pkg::END_W'(cap_sat) << bsrf_pkg::BIDX_W;
    end

    // Classify the command into a work entry for the back end.
    always_comb begin
        entry.op         = bsrf_pkg::OP_NONE;
        entry.first_word = pos_word;
        entry.last_word  = pos_word;
        entry.lo_bit     = pos_bit;
        entry.hi_bit     = bsrf_pkg::HI_W'(pos_bit) + bsrf_pkg::HI_W'(1);
        entry.value      = 1'b0;
        entry.oor        = 1'b0;
        unique case (cmd)
            bsrf_pkg::CMD_READ: begin
                if (pos_x >= cap_bits) begin
                    entry.oor = 1'b1;
                end else begin
                    entry.op = bsrf_pkg::OP_READ;
                end
            end
            bsrf_pkg::CMD_SET, bsrf_pkg::CMD_CLEAR: begin
                entry.value = (cmd == bsrf_pkg::CMD_SET);
                if (pos_x >= cap_bits) begin
                    entry.oor = 1'b1;
                end else begin
                    entry.op = bsrf_pkg::OP_WRITE;
                end
            end
            bsrf_pkg::CMD_FILL: begin
                entry.value     = fill_value;
                entry.last_word = end_m1[bsrf_pkg::BIDX_W +: bsrf_pkg::WIDX_W];
                entry.hi_bit    = bsrf_pkg::HI_W'(end_m1[bsrf_pkg::BIDX_W-1:0]) +
                                  bsrf_pkg::HI_W'(1);
                if (range_end < pos_x || range_end > cap_bits) begin
                    entry.oor = 1'b1;
                end else if (range_end != pos_x) begin
                    entry.op = bsrf_pkg::OP_WRITE;
                end
            end
            default: begin
                entry.op = bsrf_pkg::OP_NONE;
            end
        endcase
    end

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign push_entry = entry;

endmodule

FILE: design/bsrf_queue.sv
// Short queue of classified commands between the front and back ends.
`timescale 1ns / 1ps

module bsrf_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  bsrf_pkg::bsrf_entry_t push_entry,
    input  logic                  pop_req,
    output logic                  head_valid,
    output bsrf_pkg::bsrf_entry_t head_entry
);

    bsrf_pkg::bsrf_entry_t         slots_reg [bsrf_pkg::QUEUE_DEPTH];
    logic [bsrf_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [bsrf_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [bsrf_pkg::QCNT_W-1:0]   count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != bsrf_pkg::QCNT_W'(bsrf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_req && head_valid;

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == bsrf_pkg::QPTR_W'(bsrf_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + bsrf_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == bsrf_pkg::QPTR_W'(bsrf_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + bsrf_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + bsrf_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - bsrf_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

FILE: design/bsrf_back.sv
// Back end: word memory, read-modify-write sequencer and result register.
`timescale 1ns / 1ps

module bsrf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  bsrf_pkg::bsrf_entry_t         head_entry,
    output logic                          pop_req,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bsrf_pkg::M_DATA_W-1:0] m_tdata
);

    bsrf_pkg::bsrf_state_t             state_reg;
    bsrf_pkg::bsrf_state_t             state_next;
    bsrf_pkg::bsrf_entry_t             cmd_reg;
    logic [bsrf_pkg::WIDX_W-1:0]       word_reg;
    logic                              bitv_reg;
    logic [bsrf_pkg::WORD_BITS-1:0]    mem [bsrf_pkg::NUM_WORDS];
    logic [bsrf_pkg::NUM_WORDS-1:0]    vld_reg;
    logic [bsrf_pkg::WORD_BITS-1:0]    rd_data_reg;
    logic                              rd_vld_reg;
    logic [bsrf_pkg::WIDX_W-1:0]       rd_addr;
    logic                              mem_we;
    logic                              load_result;
    logic                              at_last;
    logic [bsrf_pkg::BIDX_W-1:0]       lo_eff;
    logic [bsrf_pkg::HI_W-1:0]         hi_eff;
    logic [bsrf_pkg::WORD_BITS-1:0]    mask;
    logic [bsrf_pkg::WORD_BITS-1:0]    cur_word;
    logic [bsrf_pkg::WORD_BITS-1:0]    new_word;
    logic                              m_tvalid_reg;
    logic [1:0]                        m_bits_reg;

    // Current word and its edge mask.
    always_comb begin
        at_last  = (word_reg == cmd_reg.last_word);
        lo_eff   = (word_reg == cmd_reg.first_word) ? cmd_reg.lo_bit : '0;
        hi_eff   = at_last ? cmd_reg.hi_bit : bsrf_pkg::HI_W'(bsrf_pkg::WORD_BITS);
        mask     = bsrf_pkg::low_ones(hi_eff) & ~bsrf_pkg::low_ones(bsrf_pkg::HI_W'(lo_eff));
        cur_word = rd_vld_reg ? rd_data_reg : '0;
        new_word = cmd_reg.value ? (cur_word | mask) : (cur_word & ~mask);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsrf_pkg::ST_IDLE: begin
                if (head_valid) begin
                    state_next = (head_entry.op == bsrf_pkg::OP_NONE) ?
                                 bsrf_pkg::ST_RESULT : bsrf_pkg::ST_READ;
                end
            end
            bsrf_pkg::ST_READ: begin
                state_next = bsrf_pkg::ST_MODIFY;
            end
            bsrf_pkg::ST_MODIFY: begin
                if (cmd_reg.op != bsrf_pkg::OP_WRITE || at_last) begin
                    state_next = bsrf_pkg::ST_RESULT;
                end
            end
            bsrf_pkg::ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = bsrf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bsrf_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs. While modifying one word the next word is already read.
    always_comb begin
        pop_req     = 1'b0;
        mem_we      = 1'b0;
        load_result = 1'b0;
        rd_addr     = word_reg;
        unique case (state_reg)
            bsrf_pkg::ST_IDLE: begin
                pop_req = 1'b1;
            end
            bsrf_pkg::ST_READ: begin
                rd_addr = word_reg;
            end
            bsrf_pkg::ST_MODIFY: begin
                rd_addr = word_reg + bsrf_pkg::WIDX_W'(1);
                mem_we  = (cmd_reg.op == bsrf_pkg::OP_WRITE);
            end
            bsrf_pkg::ST_RESULT: begin
                load_result = !m_tvalid_reg || m_tready;
            end
            default: begin
                pop_req = 1'b0;
            end
        endcase
    end

    // Word memory with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[word_reg] <= new_word;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Per-word valid bits stand in for clearing the memory at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                vld_reg[word_reg] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bsrf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == bsrf_pkg::ST_IDLE && head_valid) begin
            cmd_reg  <= head_entry;
            word_reg <= head_entry.first_word;
            bitv_reg <= 1'b0;
        end else if (state_reg == bsrf_pkg::ST_MODIFY) begin
            word_reg <= word_reg + bsrf_pkg::WIDX_W'(1);
            if (cmd_reg.op == bsrf_pkg::OP_READ) begin
                bitv_reg <= cur_word[cmd_reg.lo_bit];
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_result) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_result) begin
            m_bits_reg <= {cmd_reg.oor, bitv_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(bsrf_pkg::M_DATA_W - 2)'(0), m_bits_reg};

    // Memory is written only while a write command walks its words.
    a_we_in_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == bsrf_pkg::ST_MODIFY && cmd_reg.op == bsrf_pkg::OP_WRITE))
        else $error("memory write outside a write command");

    // The word walk never passes the last word of the range.
    a_word_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bsrf_pkg::ST_MODIFY) |-> (word_reg <= cmd_reg.last_word))
        else $error("word walk passed the range end");

    // A rejected command never reports a set bit.
    a_oor_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |-> !(cmd_reg.oor && bitv_reg))
        else $error("out of range result carries a bit value");

    // A result is loaded only when the result register can take it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

endmodule

FILE: design/bitmap_store_with_range_fill_core.sv
// Top level of the bitmap store with single-bit access and range fill.
`timescale 1ns / 1ps

// Bitmap of 64 words of 64 bits, cleared at reset through per-word valid
// bits, so no clearing pass is needed and commands are taken right after
// reset. Each input beat is one command (read, set, clear or range fill) and
// gives exactly one result beat. The front end checks the command against
// the capacity register and queues it; the back end walks the words with one
// read-modify-write per cycle on a memory with a write port and a registered
// read port. A rejected or empty command goes from idle straight to the result
// state; a single-bit command or a fill passes a read state, then one modify
// step per word, then the result state. Up to two commands wait in the queue
// while the back end works or a result is held by the output register.
module bitmap_store_with_range_fill_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bsrf_pkg::CAP_W-1:0]    cfg_wr_data,     // capacity_words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cmd[1:0], bit_position[13:2], range_end[26:14], fill_value[27], zero fill
    input  logic [bsrf_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // bit_value[0], out_of_range[1], zero fill
    output logic [bsrf_pkg::M_DATA_W-1:0] m_tdata
);

    logic                  push_valid;
    logic                  push_ready;
    bsrf_pkg::bsrf_entry_t push_entry;
    logic                  pop_req;
    logic                  head_valid;
    bsrf_pkg::bsrf_entry_t head_entry;

    bsrf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    bsrf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_req    (pop_req),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    bsrf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop_req    (pop_req),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: tb/bitmap_store_with_range_fill_core_tb.sv
// Self-checking testbench for the bitmap store with single-bit access and range fill.
`timescale 1ns / 1ps

module bitmap_store_with_range_fill_core_tb;

    // Cycles to let pass after the last result before a capacity write or the end.
    localparam int DRAIN_PAUSE  = 80;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT  = 4000;
    // Length of the long output hold that fills up the block.
    localparam int HOLD_LEN     = 400;
    // Mismatch lines printed before further ones are only counted.
    localparam int PRINT_LIMIT  = 40;

    // Result beat as it appears on m_tdata, lowest bit last in the list.
    typedef struct packed {
        logic [bsrf_pkg::M_DATA_W-3:0] zero_fill;
        logic                          out_of_range;
        logic                          bit_value;
    } bitmap_result_t;

    // Block ports; the inputs are driven to known values from time zero.
    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [bsrf_pkg::CAP_W-1:0]    cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [bsrf_pkg::S_DATA_W-1:0] s_tdata     = '0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [bsrf_pkg::M_DATA_W-1:0] m_tdata;

    // Predictor state: its own copy of the store and of the capacity register.
    logic [bsrf_pkg::WORD_BITS-1:0] bitmap_model [bsrf_pkg::NUM_WORDS];
    logic [bsrf_pkg::CAP_W-1:0]     model_capacity;
    bitmap_result_t                 expected_results [$];

    // Idling controls and the long-hold request.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    // Bookkeeping.
    int mismatch_count  = 0;
    int commands_seen   = 0;
    int fills_seen      = 0;
    int oor_seen        = 0;
    int results_checked = 0;
    int cap_settings    = 0;
    int cur_cap_bits    = 0;
    int idle_cycles     = 0;

    bitmap_store_with_range_fill_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // 10 ns clock.
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Print one mismatch line (up to a limit) and count it.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Work out the result of one command and apply its effect to the model store.
    function automatic bitmap_result_t predict_command(
            input logic [bsrf_pkg::CMD_W-1:0] cmd,
            input logic [bsrf_pkg::POS_W-1:0] pos,
            input logic [bsrf_pkg::END_W-1:0] rend,
            input logic                       fval);
        bitmap_result_t r;
        int usable_bits;
        int wi;
        int bi;
        int n;
        r = '0;
        usable_bits = ((model_capacity > bsrf_pkg::NUM_WORDS) ?
                       bsrf_pkg::NUM_WORDS : int'(model_capacity)) * bsrf_pkg::WORD_BITS;
        wi = int'(pos) / bsrf_pkg::WORD_BITS;
        bi = int'(pos) % bsrf_pkg::WORD_BITS;
        if (cmd != bsrf_pkg::CMD_FILL) begin
            if (int'(pos) >= usable_bits) begin
                r.out_of_range = 1'b1;
            end else begin
                case (cmd)
                    bsrf_pkg::CMD_READ: begin
                        r.bit_value = bitmap_model[wi][bi];
                    end
                    bsrf_pkg::CMD_SET: begin
                        bitmap_model[wi][bi] = 1'b1;
                    end
                    default: begin
                        bitmap_model[wi][bi] = 1'b0;
                    end
                endcase
            end
        end else if (int'(rend) < int'(pos) || int'(rend) > usable_bits) begin
            r.out_of_range = 1'b1;
        end else begin
            // The fill is modeled bit by bit over the half-open range.
            for (n = int'(pos); n < int'(rend); n++) begin
                bitmap_model[n / bsrf_pkg::WORD_BITS][n % bsrf_pkg::WORD_BITS] = fval;
            end
        end
        return r;
    endfunction

    // Scoreboard: track capacity writes, predict each accepted command beat and
    // compare each accepted result beat with the oldest prediction.
    always @(posedge aclk) begin : scoreboard
        bitmap_result_t exp_r;
        bitmap_result_t got_r;
        if (!aresetn) begin
            for (int w = 0; w < bsrf_pkg::NUM_WORDS; w++) begin
                bitmap_model[w] = '0;
            end
            model_capacity = '0;
        end else begin
            if (cfg_wr_en) begin
                model_capacity = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                exp_r = predict_command(s_tdata[1:0], s_tdata[13:2], s_tdata[26:14],
                                        s_tdata[27]);
                expected_results.push_back(exp_r);
                commands_seen++;
                if (s_tdata[1:0] == bsrf_pkg::CMD_FILL) begin
                    fills_seen++;
                end
            end
            if (m_tvalid && m_tready) begin
                got_r = m_tdata;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result beat 0x%0h with nothing expected",
                                              m_tdata));
                end else begin
                    exp_r = expected_results.pop_front();
                    results_checked++;
                    if (got_r.out_of_range) begin
                        oor_seen++;
                    end
                    if (got_r.bit_value !== exp_r.bit_value) begin
                        report_mismatch($sformatf("result %0d: bit_value %b, expected %b",
                                        results_checked, got_r.bit_value, exp_r.bit_value));
                    end
                    if (got_r.out_of_range !== exp_r.out_of_range) begin
                        report_mismatch($sformatf("result %0d: out_of_range %b, expected %b",
                                        results_checked, got_r.out_of_range,
                                        exp_r.out_of_range));
                    end
                    if (got_r.zero_fill !== '0) begin
                        report_mismatch($sformatf("result %0d: unused bits 0x%0h not zero",
                                        results_checked, got_r.zero_fill));
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold whenever one is requested.
    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_LEN;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run if no beat is accepted on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one command beat, with random idle cycles first, and wait for acceptance.
    task automatic send_command(input logic [bsrf_pkg::CMD_W-1:0] cmd,
                                input logic [bsrf_pkg::POS_W-1:0] pos,
                                input logic [bsrf_pkg::END_W-1:0] rend,
                                input logic fval);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bsrf_pkg::S_DATA_W'({fval, rend, pos, cmd});
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every expected result has arrived, then pause.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    // Write the capacity register while the block is idle.
    task automatic set_capacity(input int words);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= bsrf_pkg::CAP_W'(words);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_cap_bits = ((words > bsrf_pkg::NUM_WORDS) ? bsrf_pkg::NUM_WORDS : words)
                       * bsrf_pkg::WORD_BITS;
        cap_settings++;
    endtask

    // Build one random command: mostly well-formed within capacity, some
    // deliberately malformed or out of range, the rest raw noise.
    task automatic make_random_command(input int cap_bits,
                                       output logic [bsrf_pkg::CMD_W-1:0] cmd,
                                       output logic [bsrf_pkg::POS_W-1:0] pos,
                                       output logic [bsrf_pkg::END_W-1:0] rend,
                                       output logic fval);
        int roll;
        int r2;
        int span;
        int p;
        int e;
        cmd  = bsrf_pkg::CMD_W'($urandom_range(0, 3));
        pos  = bsrf_pkg::POS_W'($urandom);
        rend = bsrf_pkg::END_W'($urandom);
        fval = 1'($urandom);
        roll = $urandom_range(0, 99);
        if (cap_bits > 0 && roll < 85) begin
            // Half the time stay near the bottom so reads hit recently written bits.
            span = cap_bits;
            if (cap_bits > 256 && $urandom_range(0, 1) == 1) begin
                span = 256;
            end
            p = $urandom_range(0, span - 1);
            if (cmd != bsrf_pkg::CMD_FILL) begin
                pos = bsrf_pkg::POS_W'(p);
            end else begin
                r2 = $urandom_range(0, 99);
                if (r2 < 3) begin
                    p = $urandom_range(0, bsrf_pkg::WORD_BITS - 1);
                    e = cap_bits;
                end else if (r2 < 10) begin
                    e = p;
                end else begin
                    e = p + ((r2 < 70) ? $urandom_range(1, 70) : $urandom_range(71, 300));
                    if (e > cap_bits) begin
                        e = cap_bits;
                    end
                end
                pos  = bsrf_pkg::POS_W'(p);
                rend = bsrf_pkg::END_W'(e);
            end
        end else if (roll < 93) begin
            if (cmd == bsrf_pkg::CMD_FILL) begin
                if (pos != '0 && $urandom_range(0, 1) == 1) begin
                    rend = bsrf_pkg::END_W'($urandom_range(0, int'(pos) - 1));
                end else begin
                    rend = bsrf_pkg::END_W'($urandom_range(cap_bits + 1, 8191));
                end
            end else if (cap_bits < 4096) begin
                pos = bsrf_pkg::POS_W'($urandom_range(cap_bits, 4095));
            end
        end
    endtask

    // Capacity edges: zero words, one word, and a value above the store size.
    task automatic test_capacity_limits();
        send_command(bsrf_pkg::CMD_READ, 12'd0, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_FILL, 12'd0, 13'd0, 1'b1);
        set_capacity(1);
        send_command(bsrf_pkg::CMD_SET, 12'd63, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_SET, 12'd64, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_FILL, 12'd0, 13'd65, 1'b1);
        send_command(bsrf_pkg::CMD_READ, 12'd63, 13'd0, 1'b0);
        set_capacity(127);
        send_command(bsrf_pkg::CMD_READ, 12'd4095, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_FILL, 12'd4000, 13'd4097, 1'b1);
        send_command(bsrf_pkg::CMD_FILL, 12'd0, 13'd8191, 1'b1);
    endtask

    // Single-bit set at both ends of the full store, clear and read at the top end, and a read of bit 1.
    task automatic test_single_bits();
        set_capacity(bsrf_pkg::NUM_WORDS);
        send_command(bsrf_pkg::CMD_SET, 12'd4095, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_READ, 12'd4095, 13'd8191, 1'b1);
        send_command(bsrf_pkg::CMD_CLEAR, 12'd4095, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_READ, 12'd4095, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_SET, 12'd0, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_READ, 12'd1, 13'd0, 1'b0);
    endtask

    // Fills: whole store, inside one word, across words, malformed and empty.
    task automatic test_range_fills();
        send_command(bsrf_pkg::CMD_FILL, 12'd0, 13'd4096, 1'b1);
        send_command(bsrf_pkg::CMD_READ, 12'd2048, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_FILL, 12'd3, 13'd61, 1'b0);
        send_command(bsrf_pkg::CMD_READ, 12'd2, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_READ, 12'd61, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_FILL, 12'd60, 13'd130, 1'b0);
        send_command(bsrf_pkg::CMD_READ, 12'd130, 13'd0, 1'b0);
        send_command(bsrf_pkg::CMD_FILL, 12'd10, 13'd5, 1'b1);
        send_command(bsrf_pkg::CMD_FILL, 12'd7, 13'd7, 1'b1);
    endtask

    // Random traffic under one idling pattern, over several capacity settings.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int chunk_items);
        int caps [4];
        logic [bsrf_pkg::CMD_W-1:0] cmd;
        logic [bsrf_pkg::POS_W-1:0] pos;
        logic [bsrf_pkg::END_W-1:0] rend;
        logic                       fval;
        caps[0] = bsrf_pkg::NUM_WORDS;
        caps[1] = $urandom_range(1, bsrf_pkg::NUM_WORDS - 1);
        caps[2] = $urandom_range(bsrf_pkg::NUM_WORDS, 127);
        caps[3] = $urandom_range(0, bsrf_pkg::NUM_WORDS);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int c = 0; c < 4; c++) begin
            set_capacity(caps[c]);
            for (int i = 0; i < chunk_items; i++) begin
                make_random_command(cur_cap_bits, cmd, pos, rend, fval);
                send_command(cmd, pos, rend, fval);
            end
        end
    endtask

    // Long output hold while commands keep coming, so the block backs up.
    task automatic test_output_backpressure();
        logic [bsrf_pkg::CMD_W-1:0] cmd;
        logic [bsrf_pkg::POS_W-1:0] pos;
        logic [bsrf_pkg::END_W-1:0] rend;
        logic                       fval;
        set_capacity(bsrf_pkg::NUM_WORDS);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests++;
        for (int i = 0; i < 100; i++) begin
            make_random_command(cur_cap_bits, cmd, pos, rend, fval);
            send_command(cmd, pos, rend, fval);
        end
    endtask

    // Test sequence.
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_capacity_limits();
        test_single_bits();
        test_range_fills();
        test_random_traffic(0, 0, 110);
        test_random_traffic(84, 0, 110);
        test_random_traffic(0, 84, 110);
        test_random_traffic(38, 38, 110);
        test_output_backpressure();

        wait_drained();
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end

        $display("Checked %0d results for %0d commands (%0d fills, %0d out of range)",
                 results_checked, commands_seen, fills_seen, oor_seen);
        $display("over %0d capacity settings, with sender gaps, output stalls and a long hold.",
                 cap_settings);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
